// ----- src/apbp_pkg.sv -----
// shared types and constants for the airtime priority burst pacer
// no dependencies
package apbp_pkg;

	localparam int TIME_W = 32;
	localparam int CNT_W  = 5;
	localparam int LEN_W  = 8;
	localparam int CLS_W  = 2;
	localparam int MASK_W = 4;
	localparam int HOLD_W = 3;
	localparam int IDX_W  = 4;
	localparam int CMD_W  = 3;

	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REPORT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLAIM  = 3'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV
	} apbp_state_t;

	typedef struct packed {
		logic cap;
		logic upd;
		logic div_go;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic start_ok;
		logic div_done;
		logic out_full;
	} dp_sts_t;

endpackage

// ----- src/apbp_div.sv -----
// restoring divider, one quotient bit per cycle, for the pacing interval
// depends on apbp_pkg
module apbp_div import apbp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [TIME_W-1:0] dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic              done,
	output logic [TIME_W-1:0] quotient
);

	localparam int ITER_W = $clog2(TIME_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [CNT_W:0]    rem_q;
	logic [TIME_W-1:0] quo_q;
	logic [CNT_W:0]    rem_sh;
	logic              fits;

	assign rem_sh = {rem_q[CNT_W-1:0], quo_q[TIME_W-1]};
	assign fits   = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(TIME_W);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, divisor} : rem_sh;
			quo_q <= {quo_q[TIME_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- src/apbp_ctrl.sv -----
// controller state machine: input acceptance, execute step, divider wait
// depends on apbp_pkg
module apbp_ctrl import apbp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    out_stall,
	input  dp_sts_t sts,
	output dp_cmd_t ctl
);

	apbp_state_t state_q;
	apbp_state_t state_nx;
	logic        slot_busy;

	// result slot still holds an untaken transfer
	assign slot_busy = sts.out_full && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_EXEC;
			end
			ST_EXEC: begin
				if (!slot_busy) state_nx = sts.start_ok ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (sts.div_done) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		ctl      = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				ctl.cap  = in_valid;
			end
			ST_EXEC: begin
				ctl.div_go = sts.start_ok && !slot_busy;
				ctl.upd    = !sts.start_ok && !slot_busy;
			end
			ST_DIV: begin
				ctl.commit = sts.div_done;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ----- src/apbp_dp.sv -----
// datapath: input capture, burst and counter state, holder logic, result register
// depends on apbp_pkg and apbp_div
module apbp_dp import apbp_pkg::*; #(
	parameter int MAX_FRAGS   = 16,
	parameter int NUM_CLASSES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           ctl,
	output dp_sts_t           sts,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [CLS_W-1:0]  class_id,
	input  logic [TIME_W-1:0] now_us,
	input  logic [CNT_W-1:0]  frag_count,
	input  logic [TIME_W-1:0] window_us,
	input  logic [LEN_W-1:0]  send_len,
	input  logic              send_ok,
	input  logic [MASK_W-1:0] active_mask,
	input  logic              out_stall,
	output logic              out_valid,
	output logic              accepted,
	output logic              send_due,
	output logic [IDX_W-1:0]  frag_index,
	output logic [CLS_W-1:0]  send_class,
	output logic              last_frag,
	output logic [HOLD_W-1:0] holder_class,
	output logic [CNT_W-1:0]  remaining,
	output logic              bursting,
	output logic [TIME_W-1:0] packets,
	output logic [TIME_W-1:0] bytes,
	output logic [TIME_W-1:0] failures
);

	localparam int SEL_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int SCAN  = (NUM_CLASSES < MASK_W) ? NUM_CLASSES : MASK_W;
	localparam logic [CNT_W-1:0]  MaxF  = CNT_W'(MAX_FRAGS);
	localparam logic [HOLD_W-1:0] IdleH = HOLD_W'(NUM_CLASSES);

	logic [CMD_W-1:0]  cmd_q;
	logic [CLS_W-1:0]  cls_q;
	logic [TIME_W-1:0] now_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] win_q;
	logic [LEN_W-1:0]  len_q;
	logic              ok_q;
	logic [MASK_W-1:0] mask_q;

	logic [TIME_W-1:0] pkt_q  [NUM_CLASSES];
	logic [TIME_W-1:0] byt_q  [NUM_CLASSES];
	logic [TIME_W-1:0] fail_q [NUM_CLASSES];
	logic [CLS_W-1:0]  owner_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  done_q;
	logic [TIME_W-1:0] intv_q;
	logic [TIME_W-1:0] due_q;

	logic              out_valid_q;
	logic              acc_q, sdue_q, last_q, bact_q;
	logic [IDX_W-1:0]  fidx_q;
	logic [CLS_W-1:0]  scls_q;
	logic [HOLD_W-1:0] hold_q;
	logic [CNT_W-1:0]  rem_q;
	logic [TIME_W-1:0] pkt_out_q, byt_out_q, fail_out_q;

	logic              div_done;
	logic [TIME_W-1:0] quotient;

	logic              in_burst, start_ok, cls_ok, tick_fire, last_nx;
	logic [TIME_W-1:0] lag;
	logic [CNT_W-1:0]  inc_done, nx_total, nx_done;
	logic              nx_active;
	logic [SEL_W-1:0]  sel;
	logic              found;
	logic [CLS_W-1:0]  hidx;
	logic              claim_ok;
	logic              rep_ok, rep_fail;
	logic [TIME_W-1:0] pkt_nx, byt_nx, fail_nx;
	logic              load;

	apbp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (ctl.div_go),
		.dividend (win_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			cmd_q  <= cmd;
			cls_q  <= class_id;
			now_q  <= now_us;
			cnt_q  <= frag_count;
			win_q  <= window_us;
			len_q  <= send_len;
			ok_q   <= send_ok;
			mask_q <= active_mask;
		end
	end

	assign in_burst  = (total_q != '0) && (done_q < total_q);
	assign start_ok  = (cmd_q == CMD_START) && !in_burst && (cnt_q != '0) && (cnt_q <= MaxF);
	assign cls_ok    = int'(cls_q) < NUM_CLASSES;
	assign sel       = SEL_W'(cls_q);
	assign lag       = now_q - due_q;
	assign tick_fire = (cmd_q == CMD_TICK) && in_burst && !lag[TIME_W-1];
	assign inc_done  = done_q + 1'b1;
	assign last_nx   = inc_done >= total_q;
	assign load      = ctl.upd || ctl.commit;

	always_comb begin
		found = 1'b0;
		hidx  = '0;
		for (int i = SCAN - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				found = 1'b1;
				hidx  = CLS_W'(i);
			end
		end
	end

	assign claim_ok = !found || (hidx >= cls_q);

	always_comb begin
		nx_total = total_q;
		nx_done  = done_q;
		if (ctl.commit) begin
			nx_total = cnt_q;
			nx_done  = '0;
		end else if (tick_fire) begin
			if (last_nx) begin
				nx_total = '0;
				nx_done  = '0;
			end else begin
				nx_done = inc_done;
			end
		end
	end

	assign nx_active = (nx_total != '0) && (nx_done < nx_total);

	assign rep_ok   = ctl.upd && (cmd_q == CMD_REPORT) && cls_ok && ok_q;
	assign rep_fail = ctl.upd && (cmd_q == CMD_REPORT) && cls_ok && !ok_q;
	assign pkt_nx   = pkt_q[sel] + TIME_W'(rep_ok);
	assign byt_nx   = byt_q[sel] + (rep_ok ? TIME_W'(len_q) : '0);
	assign fail_nx  = fail_q[sel] + TIME_W'(rep_fail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				pkt_q[i]  <= '0;
				byt_q[i]  <= '0;
				fail_q[i] <= '0;
			end
			owner_q <= '0;
			total_q <= '0;
			done_q  <= '0;
			intv_q  <= '0;
			due_q   <= '0;
		end else begin
			if (rep_ok) begin
				pkt_q[sel] <= pkt_nx;
				byt_q[sel] <= byt_nx;
			end
			if (rep_fail) begin
				fail_q[sel] <= fail_nx;
			end
			if (ctl.commit) begin
				owner_q <= cls_q;
				intv_q  <= quotient;
				due_q   <= now_q;
			end else if (ctl.upd && tick_fire) begin
				due_q <= due_q + intv_q;
			end
			if (load) begin
				total_q <= nx_total;
				done_q  <= nx_done;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_q      <= ctl.commit || (cmd_q == CMD_CLAIM && claim_ok);
			sdue_q     <= ctl.upd && tick_fire;
			fidx_q     <= (ctl.upd && tick_fire) ? done_q[IDX_W-1:0] : '0;
			scls_q     <= (ctl.upd && tick_fire) ? owner_q : '0;
			last_q     <= ctl.upd && tick_fire && last_nx;
			hold_q     <= found ? HOLD_W'(hidx) : IdleH;
			rem_q      <= nx_active ? nx_total - nx_done : '0;
			bact_q     <= nx_active;
			pkt_out_q  <= cls_ok ? pkt_nx : '0;
			byt_out_q  <= cls_ok ? byt_nx : '0;
			fail_out_q <= cls_ok ? fail_nx : '0;
		end
	end

	assign sts.start_ok = start_ok;
	assign sts.div_done = div_done;
	assign sts.out_full = out_valid_q;

	assign out_valid    = out_valid_q;
	assign accepted     = acc_q;
	assign send_due     = sdue_q;
	assign frag_index   = fidx_q;
	assign send_class   = scls_q;
	assign last_frag    = last_q;
	assign holder_class = hold_q;
	assign remaining    = rem_q;
	assign bursting     = bact_q;
	assign packets      = pkt_out_q;
	assign bytes        = byt_out_q;
	assign failures     = fail_out_q;

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.upd && ctl.commit))
		else $error("update and commit in the same cycle");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over an untaken transfer");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q == '0) |-> (done_q == '0))
		else $error("fragment count left without a burst");

	a_total_max: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= MaxF)
		else $error("burst length above limit");

	a_commit_div: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> $past(div_done || ctl.commit) || div_done)
		else $error("burst committed without quotient");

endmodule

// ----- src/airtime_priority_burst_pacer_unit.sv -----
// ticks, reports, claims and reads pass through the input register and then the result register;
// a burst start also waits in the divider state for the 32-step one-bit-per-cycle interval divider
// a new input transfer is taken only once the previous one has loaded its result or committed its burst
// the result register lets the next input transfer in while a result waits
// reset (arst_n low): counters and burst state clear to zero, no result pending
// depends on apbp_pkg, apbp_ctrl, apbp_dp, apbp_div
module airtime_priority_burst_pacer_unit import apbp_pkg::*; #(
	parameter int MAX_FRAGS   = 16,
	parameter int NUM_CLASSES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [CLS_W-1:0]  class_id,
	input  logic [TIME_W-1:0] now_us,
	input  logic [CNT_W-1:0]  frag_count,
	input  logic [TIME_W-1:0] window_us,
	input  logic [LEN_W-1:0]  send_len,
	input  logic              send_ok,
	input  logic [MASK_W-1:0] active_mask,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              accepted,
	output logic              send_due,
	output logic [IDX_W-1:0]  frag_index,
	output logic [CLS_W-1:0]  send_class,
	output logic              last_frag,
	output logic [HOLD_W-1:0] holder_class,
	output logic [CNT_W-1:0]  remaining,
	output logic              bursting,
	output logic [TIME_W-1:0] packets,
	output logic [TIME_W-1:0] bytes,
	output logic [TIME_W-1:0] failures
);

	dp_cmd_t ctl;
	dp_sts_t sts;

	apbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	apbp_dp #(
		.MAX_FRAGS   (MAX_FRAGS),
		.NUM_CLASSES (NUM_CLASSES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cmd          (cmd),
		.class_id     (class_id),
		.now_us       (now_us),
		.frag_count   (frag_count),
		.window_us    (window_us),
		.send_len     (send_len),
		.send_ok      (send_ok),
		.active_mask  (active_mask),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.accepted     (accepted),
		.send_due     (send_due),
		.frag_index   (frag_index),
		.send_class   (send_class),
		.last_frag    (last_frag),
		.holder_class (holder_class),
		.remaining    (remaining),
		.bursting     (bursting),
		.packets      (packets),
		.bytes        (bytes),
		.failures     (failures)
	);

endmodule
